@@ hw/rtl/nfca_pkg.sv @@
// shared types, widths and codes of the next-fit chunk allocator
// used by nfca_offset_div and next_fit_chunk_allocator_core; no dependencies
package nfca_pkg;

    localparam int MAX_CHUNKS = 64;
    localparam int IDX_W      = (MAX_CHUNKS > 2) ? $clog2(MAX_CHUNKS) : 1;
    localparam int CNT_W      = $clog2(MAX_CHUNKS + 1);

    // item field widths
    localparam int REQ_W   = 23;
    localparam int OFF_W   = 23;
    localparam int ST_W    = 2;
    localparam int HEAD_W  = 6;
    localparam int BO_W    = 22;
    localparam int FREED_W = 7;
    localparam int USED_W  = 7;

    localparam int IN_FIELDS_W  = REQ_W + OFF_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = ST_W + HEAD_W + BO_W + FREED_W + USED_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // configuration
    localparam int CB_W    = 17;
    localparam int NCFG_W  = 7;
    localparam int APB_A_W = 3;
    localparam int APB_D_W = 32;
    localparam logic [CB_W-1:0] CB_MAX   = CB_W'(65536);
    localparam logic [CB_W-1:0] CB_RESET = CB_W'(16);
    localparam logic [CNT_W-1:0] N_RESET =
        CNT_W'((MAX_CHUNKS < 64) ? MAX_CHUNKS : 64);

    localparam logic REG_CHUNK_BYTES   = 1'b0;
    localparam logic REG_CHUNKS_IN_USE = 1'b1;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // running byte total of a free run and the pool limit
    localparam int RB_W  = ((CNT_W + CB_W) > (REQ_W + 1)) ? (CNT_W + CB_W) : (REQ_W + 1);
    localparam int LIM_W = ((CNT_W + CB_W) > OFF_W) ? (CNT_W + CB_W) : OFF_W;
    localparam int STEP_W = $clog2(IDX_W + 1);

    typedef enum logic [1:0] {
        STS_OK         = 2'd0,
        STS_NO_SPACE   = 2'd1,
        STS_OUTSIDE    = 2'd2,
        STS_NOT_IN_USE = 2'd3
    } status_t;

    typedef struct packed {
        logic             busy;
        logic [IDX_W-1:0] owner;
    } chunk_t;

    typedef struct packed {
        logic             done;
        logic             outside;
        logic [IDX_W-1:0] head;
    } div_res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_START,
        ST_SCAN,
        ST_MARK,
        ST_DIV,
        ST_FREE_HEAD,
        ST_FOLLOW,
        ST_DONE
    } top_state_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RANGE,
        DIV_STEP
    } div_state_t;

endpackage

@@ hw/rtl/nfca_offset_div.sv @@
// offset to chunk mapping: pool range check, then restoring division by chunk size
// one quotient bit a cycle; depends on nfca_pkg
module nfca_offset_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [nfca_pkg::OFF_W-1:0] raw,
    input  logic [nfca_pkg::CB_W-1:0]  cb,
    input  logic [nfca_pkg::CNT_W-1:0] n,
    output nfca_pkg::div_res_t         res
);
    import nfca_pkg::*;

    div_state_t          state_reg, state_next;
    logic                done_reg, done_next;
    logic                outside_reg, outside_next;
    logic                sign_reg, sign_next;
    logic [LIM_W-1:0]    rem_reg, rem_next;
    logic [LIM_W-1:0]    limit_reg, limit_next;
    logic [LIM_W-1:0]    dvs_reg, dvs_next;
    logic [IDX_W-1:0]    q_reg, q_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                trial_ge;
    logic                is_outside;

    assign trial_ge   = (rem_reg >= dvs_reg);
    assign is_outside = sign_reg || (rem_reg >= limit_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            DIV_IDLE:
            begin
                if (start)
                    state_next = DIV_RANGE;
            end
            DIV_RANGE:
            begin
                state_next = is_outside ? DIV_IDLE : DIV_STEP;
            end
            DIV_STEP:
            begin
                if (step_reg == '0)
                    state_next = DIV_IDLE;
            end
            default: state_next = DIV_IDLE;
        endcase
    end

    always_comb
    begin
        done_next    = 1'b0;
        outside_next = outside_reg;
        sign_next    = sign_reg;
        rem_next     = rem_reg;
        limit_next   = limit_reg;
        dvs_next     = dvs_reg;
        q_next       = q_reg;
        step_next    = step_reg;
        unique case (state_reg)
            DIV_IDLE:
            begin
                if (start)
                begin
                    sign_next  = raw[OFF_W-1];
                    rem_next   = LIM_W'(raw[OFF_W-2:0]);
                    limit_next = LIM_W'(cb * n);
                    dvs_next   = LIM_W'(cb) << (IDX_W - 1);
                    q_next     = '0;
                    step_next  = STEP_W'(IDX_W - 1);
                end
            end
            DIV_RANGE:
            begin
                outside_next = is_outside;
                done_next    = is_outside;
            end
            DIV_STEP:
            begin
                q_next    = (q_reg << 1) | IDX_W'(trial_ge);
                rem_next  = trial_ge ? (rem_reg - dvs_reg) : rem_reg;
                dvs_next  = dvs_reg >> 1;
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0)
                    done_next = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        outside_reg <= outside_next;
        sign_reg    <= sign_next;
        rem_reg     <= rem_next;
        limit_reg   <= limit_next;
        dvs_reg     <= dvs_next;
        q_reg       <= q_next;
        step_reg    <= step_next;
    end

    assign res.done    = done_reg;
    assign res.outside = outside_reg;
    assign res.head    = q_reg;

endmodule

@@ hw/rtl/next_fit_chunk_allocator_core.sv @@
// top level of the next-fit chunk allocator: stream ports, apb registers, chunk memory
// and the request sequencer; depends on nfca_pkg and nfca_offset_div
//
// One request at a time. Chunk state (busy mark and owner) sits in a 64-entry memory
// with a registered read; busy marks are qualified by per-entry valid flops
// that reset and any register write clear at once, so no clearing pass is needed.
// An allocate walks the pool one chunk a cycle from the cursor to the end, then, if no run
// fits, from chunk 0 over the whole pool, and writes one chunk a cycle to mark the run.
// A free takes a range check, then division by the chunk size, then releases the head chunk
// and each following chunk of the same owner.
// A finished result waits in the output register while the next item is accepted.
module next_fit_chunk_allocator_core (
    input  logic                             clk,
    input  logic                             rst_n,
    // request items
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [22:0] request_bytes, [45:23] free_offset, rest zero
    input  logic [nfca_pkg::IN_TDATA_W-1:0]  s_tdata,
    // [0] req_type
    input  logic [0:0]                       s_tuser,
    // result items
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [1:0] status, [7:2] head_chunk, [29:8] byte_offset, [36:30] freed_chunks,
    // [43:37] used_chunks, rest zero
    output logic [nfca_pkg::OUT_TDATA_W-1:0] m_tdata,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [nfca_pkg::APB_A_W-1:0]     paddr,
    input  logic [nfca_pkg::APB_D_W-1:0]     pwdata,
    output logic [nfca_pkg::APB_D_W-1:0]     prdata,
    output logic                             pready
);
    import nfca_pkg::*;

    // configuration registers
    logic [CB_W-1:0]  cb_reg;
    logic [CNT_W-1:0] n_reg;
    logic             cfg_wr;
    logic [CB_W-1:0]  cb_wr;
    logic [CB_W-1:0]  cb_sat;
    logic [NCFG_W-1:0] n_wr;
    logic [CNT_W-1:0] n_sat;

    // chunk memory
    chunk_t           mem [MAX_CHUNKS];
    chunk_t           rd_data_reg;
    logic             rd_vld_reg;
    logic [MAX_CHUNKS-1:0] valid_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    chunk_t           mem_wd;
    logic [IDX_W-1:0] mem_ra;
    logic             rd_busy;

    // sequencer
    top_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cursor_reg, cursor_next;
    logic [CNT_W-1:0] busy_count_reg, busy_count_next;
    logic             pass_reg, pass_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] run_reg, run_next;
    logic [RB_W-1:0]  run_bytes_reg, run_bytes_next;
    logic [REQ_W-1:0] bytes_reg, bytes_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] need_reg, need_next;
    logic [CNT_W-1:0] mark_k_reg, mark_k_next;
    logic [IDX_W-1:0] c_reg, c_next;
    logic [CNT_W-1:0] freed_reg, freed_next;

    // result held for the output register
    status_t          res_status_reg, res_status_next;
    logic [IDX_W-1:0] res_head_reg, res_head_next;
    logic [BO_W-1:0]  res_off_reg, res_off_next;
    logic [CNT_W-1:0] res_freed_reg, res_freed_next;

    logic             m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic             load_out;

    // divider
    logic             div_start;
    div_res_t         div_res;

    // scan and follow evaluation
    logic [IDX_W-1:0] start_idx;
    logic [CNT_W-1:0] cur_new;
    logic [CNT_W-1:0] run_new;
    logic [RB_W-1:0]  run_bytes_new;
    logic             scan_hit;
    logic             scan_last;
    logic             mark_last;
    logic             head_ok;
    logic [IDX_W-1:0] c_first;
    logic             follow_match;
    logic             follow_last;
    logic [REQ_W-1:0] in_bytes;

    assign in_bytes = s_tdata[REQ_W-1:0];

    // apb port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign cb_wr  = pwdata[CB_W-1:0];
    assign n_wr   = pwdata[NCFG_W-1:0];

    always_comb
    begin
        priority if (cb_wr == '0)
            cb_sat = CB_W'(1);
        else if (cb_wr > CB_MAX)
            cb_sat = CB_MAX;
        else
            cb_sat = cb_wr;
        priority if (n_wr == '0)
            n_sat = CNT_W'(1);
        else if (32'(n_wr) > 32'(MAX_CHUNKS))
            n_sat = CNT_W'(MAX_CHUNKS);
        else
            n_sat = CNT_W'(n_wr);
    end

    assign prdata = (paddr[2] == REG_CHUNKS_IN_USE) ? APB_D_W'(n_reg) : APB_D_W'(cb_reg);

    nfca_offset_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .raw   (s_tdata[REQ_W +: OFF_W]),
        .cb    (cb_reg),
        .n     (n_reg),
        .res   (div_res)
    );

    assign rd_busy = rd_vld_reg && rd_data_reg.busy;

    assign start_idx     = pass_reg ? '0 : cursor_reg[IDX_W-1:0];
    assign cur_new       = (run_reg == '0) ? CNT_W'(idx_reg) : cursor_reg;
    assign run_new       = rd_busy ? '0 : (run_reg + CNT_W'(1));
    assign run_bytes_new = rd_busy ? '0 : (run_bytes_reg + RB_W'(cb_reg));
    assign scan_hit      = !rd_busy && (run_bytes_new >= RB_W'(bytes_reg));
    assign scan_last     = ((CNT_W'(idx_reg) + CNT_W'(1)) == n_reg);
    assign mark_last     = ((mark_k_reg + CNT_W'(1)) == need_reg);
    assign head_ok       = (CNT_W'(head_reg) < n_reg) && rd_busy;
    // the last chunk goes on to chunk 0
    assign c_first       = ((CNT_W'(head_reg) + CNT_W'(1)) < n_reg) ?
                           (head_reg + IDX_W'(1)) : '0;
    // c equal to head only in a one-chunk pool, where the head was just released
    assign follow_match  = rd_busy && (rd_data_reg.owner == head_reg) && (c_reg != head_reg);
    assign follow_last   = ((CNT_W'(c_reg) + CNT_W'(1)) >= n_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = (s_tuser[0] == REQ_FREE) ? ST_DIV : ST_SCAN_START;
            end
            ST_SCAN_START:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                priority if (scan_hit)
                    state_next = ST_MARK;
                else if (scan_last)
                    state_next = pass_reg ? ST_DONE : ST_SCAN_START;
                else
                    state_next = ST_SCAN;
            end
            ST_MARK:
            begin
                if (mark_last)
                    state_next = ST_DONE;
            end
            ST_DIV:
            begin
                if (div_res.done)
                    state_next = div_res.outside ? ST_DONE : ST_FREE_HEAD;
            end
            ST_FREE_HEAD:
            begin
                state_next = head_ok ? ST_FOLLOW : ST_DONE;
            end
            ST_FOLLOW:
            begin
                if (!follow_match || follow_last)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        cursor_next     = cursor_reg;
        busy_count_next = busy_count_reg;
        pass_next       = pass_reg;
        idx_next        = idx_reg;
        run_next        = run_reg;
        run_bytes_next  = run_bytes_reg;
        bytes_next      = bytes_reg;
        head_next       = head_reg;
        need_next       = need_reg;
        mark_k_next     = mark_k_reg;
        c_next          = c_reg;
        freed_next      = freed_reg;
        res_status_next = res_status_reg;
        res_head_next   = res_head_reg;
        res_off_next    = res_off_reg;
        res_freed_next  = res_freed_reg;
        mem_we          = 1'b0;
        mem_wa          = head_reg;
        mem_wd          = '{busy: 1'b0, owner: head_reg};
        mem_ra          = '0;
        div_start       = 1'b0;
        load_out        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    bytes_next = (in_bytes == '0) ? REQ_W'(1) : in_bytes;
                    pass_next  = (cursor_reg < n_reg) ? 1'b0 : 1'b1;
                    div_start  = (s_tuser[0] == REQ_FREE);
                end
            end
            ST_SCAN_START:
            begin
                mem_ra         = start_idx;
                idx_next       = start_idx;
                run_next       = '0;
                run_bytes_next = '0;
            end
            ST_SCAN:
            begin
                // read one chunk ahead while the current one is judged
                mem_ra         = idx_reg + IDX_W'(1);
                cursor_next    = cur_new;
                run_next       = run_new;
                run_bytes_next = run_bytes_new;
                priority if (scan_hit)
                begin
                    head_next   = cur_new[IDX_W-1:0];
                    need_next   = run_new;
                    mark_k_next = '0;
                end
                else if (scan_last)
                begin
                    if (!pass_reg)
                        pass_next = 1'b1;
                    else
                    begin
                        res_status_next = STS_NO_SPACE;
                        res_head_next   = '0;
                        res_off_next    = '0;
                        res_freed_next  = '0;
                    end
                end
                else
                    idx_next = idx_reg + IDX_W'(1);
            end
            ST_MARK:
            begin
                mem_we          = 1'b1;
                mem_wa          = head_reg + mark_k_reg[IDX_W-1:0];
                mem_wd          = '{busy: 1'b1, owner: head_reg};
                busy_count_next = busy_count_reg + CNT_W'(1);
                mark_k_next     = mark_k_reg + CNT_W'(1);
                if (mark_last)
                begin
                    cursor_next     = CNT_W'(head_reg) + need_reg;
                    res_status_next = STS_OK;
                    res_head_next   = head_reg;
                    res_off_next    = BO_W'(head_reg * cb_reg);
                    res_freed_next  = '0;
                end
            end
            ST_DIV:
            begin
                mem_ra = div_res.head;
                if (div_res.done)
                begin
                    head_next = div_res.head;
                    if (div_res.outside)
                    begin
                        res_status_next = STS_OUTSIDE;
                        res_head_next   = '0;
                        res_off_next    = '0;
                        res_freed_next  = '0;
                    end
                end
            end
            ST_FREE_HEAD:
            begin
                mem_ra = c_first;
                if (head_ok)
                begin
                    mem_we          = 1'b1;
                    mem_wa          = head_reg;
                    busy_count_next = busy_count_reg - CNT_W'(1);
                    freed_next      = CNT_W'(1);
                    c_next          = c_first;
                end
                else
                begin
                    res_status_next = STS_NOT_IN_USE;
                    res_head_next   = head_reg;
                    res_off_next    = '0;
                    res_freed_next  = '0;
                end
            end
            ST_FOLLOW:
            begin
                mem_ra = c_reg + IDX_W'(1);
                if (follow_match)
                begin
                    mem_we          = 1'b1;
                    mem_wa          = c_reg;
                    busy_count_next = busy_count_reg - CNT_W'(1);
                    freed_next      = freed_reg + CNT_W'(1);
                    c_next          = c_reg + IDX_W'(1);
                end
                if (!follow_match || follow_last)
                begin
                    res_status_next = STS_OK;
                    res_head_next   = head_reg;
                    res_off_next    = '0;
                    res_freed_next  = follow_match ? (freed_reg + CNT_W'(1)) : freed_reg;
                end
            end
            ST_DONE:
            begin
                load_out = !m_tvalid_reg || m_tready;
            end
            default:
            begin
                load_out = 1'b0;
            end
        endcase

        // a register write forms a fresh pool
        if (cfg_wr)
        begin
            cursor_next     = '0;
            busy_count_next = '0;
        end
    end

    assign m_tvalid_next = load_out ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
    assign m_tdata_next  = load_out ?
        OUT_TDATA_W'({USED_W'(busy_count_reg), FREED_W'(res_freed_reg), res_off_reg,
                      HEAD_W'(res_head_reg), ST_W'(res_status_reg)}) :
        m_tdata_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cursor_reg     <= '0;
            busy_count_reg <= '0;
            cb_reg         <= CB_RESET;
            n_reg          <= N_RESET;
            valid_reg      <= '0;
            rd_vld_reg     <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cursor_reg     <= cursor_next;
            busy_count_reg <= busy_count_next;
            m_tvalid_reg   <= m_tvalid_next;
            rd_vld_reg     <= valid_reg[mem_ra];
            if (cfg_wr)
            begin
                valid_reg <= '0;
                if (paddr[2] == REG_CHUNKS_IN_USE)
                    n_reg <= n_sat;
                else
                    cb_reg <= cb_sat;
            end
            else if (mem_we)
                valid_reg[mem_wa] <= 1'b1;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pass_reg       <= pass_next;
        idx_reg        <= idx_next;
        run_reg        <= run_next;
        run_bytes_reg  <= run_bytes_next;
        bytes_reg      <= bytes_next;
        head_reg       <= head_next;
        need_reg       <= need_next;
        mark_k_reg     <= mark_k_next;
        c_reg          <= c_next;
        freed_reg      <= freed_next;
        res_status_reg <= res_status_next;
        res_head_reg   <= res_head_next;
        res_off_reg    <= res_off_next;
        res_freed_reg  <= res_freed_next;
        m_tdata_reg    <= m_tdata_next;
    end

    // chunk memory, read data registered
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        rd_data_reg <= mem[mem_ra];
    end

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg != ST_IDLE))
        else $error("accepted item did not start work");

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_MARK || state_reg == ST_FREE_HEAD ||
                    state_reg == ST_FOLLOW))
        else $error("chunk memory written outside mark or release");

    a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result raised without a finished request");

    a_div_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        div_res.done |=> !div_res.done)
        else $error("divider done held longer than one cycle");

endmodule
